>>> hdl/rsfl_pkg.sv
// rsfl_pkg: shared types and constants for the record slot free list
// depends on nothing; used by record_slot_free_list_top
package rsfl_pkg;

    localparam int SLOTS       = 1024;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int KEY_W       = 32;
    localparam int OUT_SLOT_W  = 10;
    localparam int OUT_TDATA_W = 16;
    localparam int STATUS_W    = 3;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_REUSED    = 3'd0,
        STAT_APPENDED  = 3'd1,
        STAT_INVALID   = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_REMOVED   = 3'd4,
        STAT_NOT_FOUND = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

>>> hdl/record_slot_free_list_top.sv
// record_slot_free_list_top: key store with a lifo free list threaded through freed slots
// depends on rsfl_pkg; holds the 1024 x 32 key memory and its sequencer
// insert: append, reject and full pass through S_DONE to the output register; reuse goes through S_POP first
// remove: S_SCAN makes one memory read per slot scanned, up to used_slots, then S_DONE
// one item at a time: the next item is accepted only after the result loads into the output
// register and the sequencer returns to idle; a result held by o_m_axis_tready stalls the input
// reset: synchronous active low; free list empty and used count zero, memory not cleared
module record_slot_free_list_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [rsfl_pkg::KEY_W-1:0]         i_s_axis_tdata,  // [31:0] key
    input  logic                               i_s_axis_tuser,  // [0] command
    // result item stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [rsfl_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,  // [9:0] slot, [15:10] zero
    output logic [rsfl_pkg::STATUS_W-1:0]      o_m_axis_tuser   // [2:0] status
);

    // key memory, one write and one registered read per cycle
    // a slot that was never written is never read: only slots below the used count are scanned
    logic [rsfl_pkg::KEY_W-1:0]  r_mem [rsfl_pkg::SLOTS];
    logic [rsfl_pkg::KEY_W-1:0]  r_rdata;

    // sequencer and architectural state
    rsfl_pkg::t_state            r_state, n_state;
    logic                        r_head_vld, n_head_vld;    // free list not empty
    logic [rsfl_pkg::SLOT_W-1:0] r_head_idx, n_head_idx;
    logic [rsfl_pkg::CNT_W-1:0]  r_used, n_used;

    // per item working registers
    logic [rsfl_pkg::KEY_W-1:0]  r_key, n_key;
    logic [rsfl_pkg::CNT_W-1:0]  r_idx, n_idx;              // next slot to read in the scan
    logic                        r_cmp_vld, n_cmp_vld;      // r_rdata belongs to r_cmp_idx
    logic [rsfl_pkg::SLOT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [rsfl_pkg::SLOT_W-1:0] r_res_slot, n_res_slot;
    rsfl_pkg::t_status           r_res_status, n_res_status;

    // output register
    logic                        r_out_vld, n_out_vld;
    logic [rsfl_pkg::SLOT_W-1:0] r_out_slot, n_out_slot;
    rsfl_pkg::t_status           r_out_status, n_out_status;

    // memory port controls
    logic                        w_we, w_re;
    logic [rsfl_pkg::SLOT_W-1:0] w_waddr, w_raddr;
    logic [rsfl_pkg::KEY_W-1:0]  w_wdata;

    // handshake and shared compare results
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_issue;        // a slot below the used count is left to read
    logic                        w_hit;          // read data is a live slot holding the key
    logic                        w_link_vld;     // decoded link points inside the store
    logic [rsfl_pkg::SLOT_W-1:0] w_link_idx;
    logic [rsfl_pkg::KEY_W-1:0]  w_link_inv;
    logic [rsfl_pkg::KEY_W-1:0]  w_link_enc;

    assign o_s_axis_tready = (r_state == rsfl_pkg::S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_vld || i_m_axis_tready;
    assign w_issue         = (r_idx < r_used);
    assign w_hit           = r_cmp_vld && !r_rdata[rsfl_pkg::KEY_W-1] && (r_rdata == r_key);

    // stored link is -(next + 2), so next = ~stored - 1; ~stored in 1..SLOTS is a slot
    assign w_link_inv = ~r_rdata;
    assign w_link_vld = r_rdata[rsfl_pkg::KEY_W-1] && (w_link_inv != '0)
                        && (w_link_inv <= rsfl_pkg::KEY_W'(rsfl_pkg::SLOTS));
    assign w_link_idx = rsfl_pkg::SLOT_W'(w_link_inv - rsfl_pkg::KEY_W'(1));

    // encoding the current head: ~(head + 1), all ones when the list is empty
    assign w_link_enc = r_head_vld
                        ? ~(rsfl_pkg::KEY_W'(r_head_idx) + rsfl_pkg::KEY_W'(1))
                        : '1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rsfl_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == rsfl_pkg::CMD_REMOVE) begin
                        n_state = rsfl_pkg::S_SCAN;
                    end else if (!i_s_axis_tdata[rsfl_pkg::KEY_W-1] && r_head_vld) begin
                        n_state = rsfl_pkg::S_POP;
                    end else begin
                        n_state = rsfl_pkg::S_DONE;
                    end
                end
            end
            rsfl_pkg::S_POP: begin
                n_state = rsfl_pkg::S_DONE;
            end
            rsfl_pkg::S_SCAN: begin
                if (w_hit || (!w_issue && !r_cmp_vld)) begin
                    n_state = rsfl_pkg::S_DONE;
                end
            end
            rsfl_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = rsfl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsfl_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_head_vld   = r_head_vld;
        n_head_idx   = r_head_idx;
        n_used       = r_used;
        n_key        = r_key;
        n_idx        = r_idx;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_head_idx;
        w_wdata      = r_key;
        w_re         = 1'b0;
        w_raddr      = r_head_idx;

        case (r_state)
            rsfl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key     = i_s_axis_tdata;
                    n_idx     = '0;
                    n_cmp_vld = 1'b0;
                    if (i_s_axis_tuser == rsfl_pkg::CMD_INSERT) begin
                        if (i_s_axis_tdata[rsfl_pkg::KEY_W-1]) begin
                            n_res_slot   = '0;
                            n_res_status = rsfl_pkg::STAT_INVALID;
                        end else if (r_head_vld) begin
                            // fetch the head slot to learn the next link
                            w_re = 1'b1;
                        end else if (r_used < rsfl_pkg::CNT_W'(rsfl_pkg::SLOTS)) begin
                            w_we         = 1'b1;
                            w_waddr      = r_used[rsfl_pkg::SLOT_W-1:0];
                            w_wdata      = i_s_axis_tdata;
                            n_used       = r_used + rsfl_pkg::CNT_W'(1);
                            n_res_slot   = r_used[rsfl_pkg::SLOT_W-1:0];
                            n_res_status = rsfl_pkg::STAT_APPENDED;
                        end else begin
                            n_res_slot   = '0;
                            n_res_status = rsfl_pkg::STAT_FULL;
                        end
                    end
                end
            end
            rsfl_pkg::S_POP: begin
                // pop: head moves to the stored link, slot takes the key
                w_we         = 1'b1;
                w_waddr      = r_head_idx;
                w_wdata      = r_key;
                n_head_vld   = w_link_vld;
                n_head_idx   = w_link_idx;
                n_res_slot   = r_head_idx;
                n_res_status = rsfl_pkg::STAT_REUSED;
            end
            rsfl_pkg::S_SCAN: begin
                if (w_hit) begin
                    // push the matched slot onto the free list
                    w_we         = 1'b1;
                    w_waddr      = r_cmp_idx;
                    w_wdata      = w_link_enc;
                    n_head_vld   = 1'b1;
                    n_head_idx   = r_cmp_idx;
                    n_res_slot   = r_cmp_idx;
                    n_res_status = rsfl_pkg::STAT_REMOVED;
                end else if (!w_issue && !r_cmp_vld) begin
                    n_res_slot   = '0;
                    n_res_status = rsfl_pkg::STAT_NOT_FOUND;
                end else begin
                    // read one slot ahead of the compare
                    w_raddr   = r_idx[rsfl_pkg::SLOT_W-1:0];
                    w_re      = w_issue;
                    n_cmp_vld = w_issue;
                    n_cmp_idx = r_idx[rsfl_pkg::SLOT_W-1:0];
                    if (w_issue) begin
                        n_idx = r_idx + rsfl_pkg::CNT_W'(1);
                    end
                end
            end
            rsfl_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                n_out_vld = r_out_vld;
            end
        endcase
    end

    // key memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= rsfl_pkg::S_IDLE;
            r_head_vld <= 1'b0;
            r_used     <= '0;
            r_out_vld  <= 1'b0;
            r_cmp_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head_vld <= n_head_vld;
            r_used     <= n_used;
            r_out_vld  <= n_out_vld;
            r_cmp_vld  <= n_cmp_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_head_idx   <= n_head_idx;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_cmp_idx    <= n_cmp_idx;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = rsfl_pkg::OUT_TDATA_W'(r_out_slot);
    assign o_m_axis_tuser  = r_out_status;

    // used count never passes the store size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= rsfl_pkg::CNT_W'(rsfl_pkg::SLOTS))
        else $error("used slot count beyond store size");

    // the free list head always lies inside the used region
    a_head_in_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head_vld |-> (rsfl_pkg::CNT_W'(r_head_idx) < r_used))
        else $error("free list head outside used region");

    // error results carry slot zero
    a_err_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == rsfl_pkg::STAT_INVALID
            || o_m_axis_tuser == rsfl_pkg::STAT_FULL
            || o_m_axis_tuser == rsfl_pkg::STAT_NOT_FOUND)) |-> (o_m_axis_tdata == '0))
        else $error("error result with nonzero slot");

    // an accepted item always leaves the idle state
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != rsfl_pkg::S_IDLE))
        else $error("item accepted but sequencer stayed idle");

    // a slot is written only while an item is being worked on
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (w_accept || r_state == rsfl_pkg::S_POP || r_state == rsfl_pkg::S_SCAN))
        else $error("memory write outside an item");

endmodule

>>> verif/record_slot_free_list_top_tb.sv
// record_slot_free_list_top_tb: self-checking bench for the key store and its lifo free list
// depends on rsfl_pkg and record_slot_free_list_top; stream drivers plus a scoreboard class
`timescale 1ns / 100ps

module record_slot_free_list_top_tb;
    import rsfl_pkg::*;

    localparam int IDLE_LIMIT = 20000;   // well above the length of a full-store scan
    localparam int DRAIN_WAIT = SLOTS + 16;

    typedef struct {
        logic [OUT_SLOT_W-1:0] slot;
        t_status               status;
    } t_outcome;

    // keeps a shadow of the key store and the queue of outcomes still owed by the block
    class slot_alloc_checker;
        logic signed [KEY_W-1:0] stored_keys [SLOTS];
        int                      list_head;
        int                      fill_count;
        t_outcome                owed_outcomes [$];
        int                      errors;

        function new();
            list_head  = -1;
            fill_count = 0;
            errors     = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t mismatch: %s", $realtime, msg);
        endtask

        // a freed slot stores -(next + 2); anything outside -1..SLOTS-1 ends the list
        function int unlink(logic signed [KEY_W-1:0] stored);
            longint nxt;
            nxt = -longint'(stored) - 2;
            if (nxt < -1 || nxt >= SLOTS) begin
                return -1;
            end
            return int'(nxt);
        endfunction

        function t_outcome predict_outcome(t_cmd op, logic signed [KEY_W-1:0] key);
            t_outcome res;
            int       s;
            res.slot   = '0;
            res.status = STAT_NOT_FOUND;
            if (op == CMD_INSERT) begin
                if (key < 0) begin
                    res.status = STAT_INVALID;
                end else if (list_head >= 0 && list_head < SLOTS) begin
                    s              = list_head;
                    list_head      = unlink(stored_keys[s]);
                    stored_keys[s] = key;
                    res.slot       = OUT_SLOT_W'(s);
                    res.status     = STAT_REUSED;
                end else begin
                    list_head = -1;
                    if (fill_count < SLOTS) begin
                        stored_keys[fill_count] = key;
                        res.slot   = OUT_SLOT_W'(fill_count);
                        res.status = STAT_APPENDED;
                        fill_count++;
                    end else begin
                        res.status = STAT_FULL;
                    end
                end
            end else begin
                // first live match wins; links are negative so they never match
                for (int i = 0; i < fill_count; i++) begin
                    if (stored_keys[i] >= 0 && stored_keys[i] == key) begin
                        stored_keys[i] = -(KEY_W'(list_head) + 2);
                        list_head      = i;
                        res.slot       = OUT_SLOT_W'(i);
                        res.status     = STAT_REMOVED;
                        break;
                    end
                end
            end
            return res;
        endfunction

        function void note_command(t_cmd op, logic signed [KEY_W-1:0] key);
            owed_outcomes.push_back(predict_outcome(op, key));
        endfunction

        task check_outcome(logic [OUT_TDATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser);
            t_outcome want;
            if (owed_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected item slot=%0d status=%0d",
                                          tdata, tuser));
                return;
            end
            want = owed_outcomes.pop_front();
            if (tdata !== OUT_TDATA_W'(want.slot)) begin
                report_mismatch($sformatf("slot got 0x%04h want %0d (status %s)",
                                          tdata, want.slot, want.status.name()));
            end
            if (tuser !== want.status) begin
                report_mismatch($sformatf("status got %0d want %s (slot %0d)",
                                          tuser, want.status.name(), want.slot));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic [KEY_W-1:0]       cmd_key = '0;
    logic                   cmd_op = 1'b0;
    logic                   res_ready = 1'b0;
    logic                   cmd_ready;
    logic                   res_valid;
    logic [OUT_TDATA_W-1:0] res_data;
    logic [STATUS_W-1:0]    res_status;

    slot_alloc_checker sb = new();
    bit                idle_on = 1'b1;
    int                rx_hold = 0;
    int                quiet_cycles = 0;

    record_slot_free_list_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_key),
        .i_s_axis_tuser  (cmd_op),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random back-pressure bursts and the check of each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && res_valid && res_ready) begin
            sb.check_outcome(res_data, res_status);
        end
        if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            res_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_hold   <= $urandom_range(0, 4);
            res_ready <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** record_slot_free_list_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(t_cmd op, logic [KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_key   <= key;
        cmd_op    <= op;
        do begin
            @(posedge i_clk);
        end while (!cmd_ready);
        sb.note_command(op, key);
    endtask

    // half from a small pool so duplicates and repeat removes happen, the rest full range or nonnegative
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 3))
            0, 1:    return KEY_W'($urandom_range(0, 15));
            2:       return $urandom;
            default: return $urandom & 32'h7fff_ffff;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_live_key();
        int idx;
        if (sb.fill_count == 0) begin
            return pick_key();
        end
        idx = $urandom_range(0, sb.fill_count - 1);
        if (sb.stored_keys[idx] < 0) begin
            return pick_key();
        end
        return sb.stored_keys[idx];
    endfunction

    task automatic send_mixed(int count, int insert_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                send_item(CMD_INSERT, pick_key());
            end else if ($urandom_range(0, 9) < 7) begin
                send_item(CMD_REMOVE, pick_live_key());
            end else begin
                send_item(CMD_REMOVE, pick_key());
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, rejects, duplicates, links that look like keys
        send_item(CMD_REMOVE, 32'd5);             // nothing stored yet
        send_item(CMD_INSERT, 32'd0);
        send_item(CMD_INSERT, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'h8000_0000);     // most negative key, rejected
        send_item(CMD_INSERT, 32'hffff_ffff);     // minus one, rejected
        send_item(CMD_INSERT, 32'd5);
        send_item(CMD_INSERT, 32'd5);             // duplicate key
        send_item(CMD_INSERT, 32'd9);
        send_item(CMD_REMOVE, 32'd5);             // first of the two copies
        send_item(CMD_REMOVE, 32'd0);
        send_item(CMD_REMOVE, 32'hffff_ffff);     // same value as an end-of-list link
        send_item(CMD_REMOVE, 32'hffff_fffc);     // same value as a link to slot 2
        send_item(CMD_REMOVE, 32'd0);             // already gone
        send_item(CMD_INSERT, 32'd11);            // reuse, last freed first
        send_item(CMD_INSERT, 32'd12);
        send_item(CMD_INSERT, 32'd13);            // list empty again, append
        send_item(CMD_REMOVE, 32'h7fff_ffff);
        send_item(CMD_REMOVE, 32'd5);
        send_item(CMD_INSERT, 32'h7fff_ffff);
        send_item(CMD_INSERT, 32'd0);

        // random mix with the store kept small, idling switched in stretches
        for (int blk = 0; blk < 9; blk++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_mixed(58, 55);
        end
        idle_on = 1'b1;
        send_item(CMD_REMOVE, 32'h8000_0000);     // scans the whole used region, no match

        // last part without idling
        idle_on = 1'b0;
        send_mixed(40, 50);
        cmd_valid <= 1'b0;

        while (sb.owed_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("** record_slot_free_list_top: PASSED **");
        end else begin
            $display("** record_slot_free_list_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/rsfl_pkg.sv
hdl/record_slot_free_list_top.sv
verif/record_slot_free_list_top_tb.sv
